>>> rtl/core/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg
// Shared widths, operation codes and constants of the block index search unit.
// ----------------------------------------------------------------------------
package bis_pkg;

   localparam int unsigned FUNC_W = 2;
   localparam int unsigned ADDR_W = 4;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned POS_W  = 4;

   typedef logic [FUNC_W-1:0]        func_type;
   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [POS_W-1:0]         pos_type;

   localparam func_type FUNC_CLEAR  = 2'd0;
   localparam func_type FUNC_WRITE  = 2'd1;
   localparam func_type FUNC_SEARCH = 2'd2;

   // Reset value of a block maximum.
   localparam data_type INT_MIN = 32'sh8000_0000;

endpackage

>>> rtl/core/bis_if.sv
// ----------------------------------------------------------------------------
// bis_req_if / bis_rsp_if
// Valid/ready channels for operation requests and search responses.
// ----------------------------------------------------------------------------
interface bis_req_if;
   import bis_pkg::*;

   logic     valid;
   logic     ready;
   func_type func;
   addr_type address;
   data_type value;

   modport source (output valid, output func, output address, output value, input ready);
   modport sink   (input valid, input func, input address, input value, output ready);
endinterface

interface bis_rsp_if;
   import bis_pkg::*;

   logic    valid;
   logic    ready;
   logic    found;
   pos_type position;

   modport source (output valid, output found, output position, input ready);
   modport sink   (input valid, input found, input position, output ready);
endinterface

>>> rtl/core/bis_max_store.sv
// ----------------------------------------------------------------------------
// bis_max_store
// Block maximum memory with a registered read. A valid bit per block
// lets a clear take effect at once; an invalid block reads as INT_MIN.
// ----------------------------------------------------------------------------
module bis_max_store #(
   parameter int unsigned NUM_BLOCKS = 4,
   parameter int unsigned BLK_W      = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic [BLK_W-1:0]     rd_addr,
   output bis_pkg::data_type    rd_data,
   input  logic                 wr_en,
   input  logic [BLK_W-1:0]     wr_addr,
   input  bis_pkg::data_type    wr_data
);
   import bis_pkg::*;

   data_type               mem_ff [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0]  vld_ff;
   data_type               rd_word_ff;
   logic                   rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_word_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_word_ff : INT_MIN;

endmodule

>>> rtl/core/bis_elem_store.sv
// ----------------------------------------------------------------------------
// bis_elem_store
// Element memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bis_elem_store #(
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ELEM_W = 4
) (
   input  logic                 clock,
   input  logic [ELEM_W-1:0]    rd_addr,
   output bis_pkg::data_type    rd_data,
   input  logic                 wr_en,
   input  logic [ELEM_W-1:0]    wr_addr,
   input  bis_pkg::data_type    wr_data
);
   import bis_pkg::*;

   data_type mem_ff [DEPTH];
   data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/block_index_search_unit.sv
// ----------------------------------------------------------------------------
// block_index_search_unit
// Indexed block search: clear of the block maxima, element write with
// maximum update, and search of the first block whose maximum reaches the key.
// ----------------------------------------------------------------------------
// A search takes one maximum read per block visited and one element read per
// element scanned. The next item is taken the cycle after the response is
// loaded into the output register, one item at a time. Reset leaves every
// block maximum at the most negative value at once; the element memory is
// not initialized.
module block_index_search_unit #(
   parameter int unsigned NUM_BLOCKS = 4,
   parameter int unsigned BLOCK_SIZE = 4
) (
   input  logic        clock,
   input  logic        reset,
   bis_req_if.sink     req_chan,
   bis_rsp_if.source   rsp_chan
);
   import bis_pkg::*;

   localparam int unsigned DEPTH  = NUM_BLOCKS * BLOCK_SIZE;
   localparam int unsigned ELEM_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned BLK_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int unsigned CNT_W  = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
   localparam int unsigned NUM_ADDR = 2 ** ADDR_W;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_WMAX  = 6'b000010,
      S_SMAX  = 6'b000100,
      S_SELEM = 6'b001000,
      S_DONE  = 6'b010000,
      S_SPARE = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   data_type           val_ff, val_in;
   logic [BLK_W-1:0]   blk_ff, blk_in;
   logic [ELEM_W-1:0]  base_ff, base_in;
   logic [ELEM_W-1:0]  j_ff, j_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               hit_ff, hit_in;
   pos_type            pos_ff, pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   pos_type            rsp_pos_ff, rsp_pos_in;

   logic [BLK_W-1:0]   addr_blk_lut [NUM_ADDR];
   logic               addr_ok_lut [NUM_ADDR];

   logic               accept;
   logic               load;
   logic               max_clear;
   logic [BLK_W-1:0]   max_raddr;
   data_type           max_rdata;
   logic               max_we;
   logic [ELEM_W-1:0]  elem_raddr;
   data_type           elem_rdata;
   logic               elem_we;

   // Block number and range check of every write address, fixed at elaboration.
   for (genvar a = 0; a < NUM_ADDR; a++) begin : g_addr
      localparam int unsigned A_OK  = (a < DEPTH) ? 1 : 0;
      localparam int unsigned A_BLK = (a < DEPTH) ? (a / BLOCK_SIZE) : 0;
      assign addr_blk_lut[a] = BLK_W'(A_BLK);
      assign addr_ok_lut[a]  = (A_OK != 0);
   end

   assign accept = req_chan.valid && req_chan.ready;
   assign load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   bis_max_store #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .BLK_W      (BLK_W)
   ) u_max (
      .clock   (clock),
      .reset   (reset),
      .clear   (max_clear),
      .rd_addr (max_raddr),
      .rd_data (max_rdata),
      .wr_en   (max_we),
      .wr_addr (blk_ff),
      .wr_data (val_ff)
   );

   bis_elem_store #(
      .DEPTH  (DEPTH),
      .ELEM_W (ELEM_W)
   ) u_elem (
      .clock   (clock),
      .rd_addr (elem_raddr),
      .rd_data (elem_rdata),
      .wr_en   (elem_we),
      .wr_addr (ELEM_W'(req_chan.address)),
      .wr_data (req_chan.value)
   );

   always_comb begin
      state_in   = state_ff;
      val_in     = val_ff;
      blk_in     = blk_ff;
      base_in    = base_ff;
      j_in       = j_ff;
      cnt_in     = cnt_ff;
      hit_in     = hit_ff;
      pos_in     = pos_ff;
      max_clear  = 1'b0;
      max_raddr  = blk_ff;
      max_we     = 1'b0;
      elem_raddr = j_ff;
      elem_we    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               val_in   = req_chan.value;
               hit_in   = 1'b0;
               pos_in   = '0;
               state_in = S_DONE;
               case (req_chan.func)
                  FUNC_CLEAR: begin
                     max_clear = 1'b1;
                  end
                  FUNC_WRITE: begin
                     if (addr_ok_lut[req_chan.address]) begin
                        elem_we   = 1'b1;
                        blk_in    = addr_blk_lut[req_chan.address];
                        max_raddr = addr_blk_lut[req_chan.address];
                        state_in  = S_WMAX;
                     end
                  end
                  FUNC_SEARCH: begin
                     blk_in    = '0;
                     base_in   = '0;
                     max_raddr = '0;
                     state_in  = S_SMAX;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_WMAX: begin
            // An overwrite only ever raises the maximum.
            max_we   = (max_rdata < val_ff);
            state_in = S_DONE;
         end
         S_SMAX: begin
            if (max_rdata < val_ff) begin
               if (blk_ff == BLK_W'(NUM_BLOCKS - 1)) begin
                  state_in = S_DONE;
               end else begin
                  blk_in    = blk_ff + 1'b1;
                  base_in   = base_ff + ELEM_W'(BLOCK_SIZE);
                  max_raddr = blk_ff + 1'b1;
               end
            end else begin
               elem_raddr = base_ff;
               j_in       = base_ff;
               cnt_in     = '0;
               state_in   = S_SELEM;
            end
         end
         S_SELEM: begin
            if (elem_rdata == val_ff) begin
               hit_in   = 1'b1;
               pos_in   = POS_W'(j_ff);
               state_in = S_DONE;
            end else if (cnt_ff == CNT_W'(BLOCK_SIZE - 1)) begin
               state_in = S_DONE;
            end else begin
               j_in       = j_ff + 1'b1;
               cnt_in     = cnt_ff + 1'b1;
               elem_raddr = j_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = hit_ff;
         rsp_pos_in   = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff       <= val_in;
      blk_ff       <= blk_in;
      base_ff      <= base_in;
      j_ff         <= j_in;
      cnt_ff       <= cnt_in;
      hit_ff       <= hit_in;
      pos_ff       <= pos_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign req_chan.ready    = (state_ff == S_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.found    = rsp_found_ff;
   assign rsp_chan.position = rsp_pos_ff;

   // A response that reports no match carries position zero.
   a_miss_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_pos_ff == '0)
      else $error("not-found response with nonzero position");

   // The element scan stays inside the block chosen by the maximum walk.
   a_scan_in_block: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SELEM |->
         (32'(j_ff) == 32'(base_ff) + 32'(cnt_ff)) && (32'(cnt_ff) < BLOCK_SIZE))
      else $error("element scan left its block");

   // An accepted item always starts work in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("item accepted without leaving idle");

   // A new response only appears out of the done state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside the done state");

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for block_index_search_unit. Directed and random clear,
// write, search and unused-code items go in over the request channel. A local
// predictor tracks the element store and the block maxima, and each response
// is compared in order with its predicted answer.
// ----------------------------------------------------------------------------
module tb;
   import bis_pkg::*;

   localparam int unsigned NUM_BLOCKS  = 4;
   localparam int unsigned BLOCK_SIZE  = 4;
   localparam int unsigned STORE_DEPTH = NUM_BLOCKS * BLOCK_SIZE;
   localparam func_type    FUNC_UNUSED = 2'd3;
   localparam data_type    INT_MAX     = 32'sh7fff_ffff;

   typedef struct packed {
      logic    found;
      pos_type position;
   } search_answer_type;

   logic clock;
   logic reset;

   bis_req_if req_if();
   bis_rsp_if rsp_if();

   block_index_search_unit #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .BLOCK_SIZE (BLOCK_SIZE)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Predictor state: a private copy of the store and of the block maxima.
   data_type idx_store [STORE_DEPTH];
   data_type blk_max   [NUM_BLOCKS];

   search_answer_type answer_q[$];

   int unsigned error_count = 0;
   int unsigned hit_count   = 0;
   int unsigned miss_count  = 0;
   int unsigned write_count = 0;
   int unsigned clear_count = 0;
   int unsigned other_count = 0;

   bit calm     = 1'b0;
   bit rsp_hold = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   function automatic search_answer_type predict_answer(func_type f, addr_type a, data_type v);
      search_answer_type ans;
      int unsigned       b;
      int unsigned       j;
      ans = '0;
      case (f)
         FUNC_CLEAR: begin
            foreach (blk_max[i]) blk_max[i] = INT_MIN;
            clear_count++;
         end
         FUNC_WRITE: begin
            if (a < STORE_DEPTH) begin
               idx_store[a] = v;
               if (blk_max[a / BLOCK_SIZE] < v) blk_max[a / BLOCK_SIZE] = v;
            end
            write_count++;
         end
         FUNC_SEARCH: begin
            b = 0;
            while (b < NUM_BLOCKS && blk_max[b] < v) b++;
            if (b < NUM_BLOCKS) begin
               for (j = b * BLOCK_SIZE; j < (b + 1) * BLOCK_SIZE; j++) begin
                  if (idx_store[j] == v) begin
                     ans.found    = 1'b1;
                     ans.position = pos_type'(j);
                     break;
                  end
               end
            end
            if (ans.found) hit_count++;
            else miss_count++;
         end
         default: other_count++;
      endcase
      return ans;
   endfunction

   // Called at a rising edge; returns at the edge where the item is taken.
   task automatic send_op(input func_type f, input addr_type a, input data_type v);
      req_if.valid   <= 1'b1;
      req_if.func    <= f;
      req_if.address <= a;
      req_if.value   <= v;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      answer_q.push_back(predict_answer(f, a, v));
   endtask

   task automatic issue(input func_type f, input addr_type a, input data_type v);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      send_op(f, a, v);
   endtask

   function automatic data_type pick_value();
      int unsigned sel;
      int          v;
      sel = $urandom_range(0, 19);
      if (sel < 8) begin
         v = $urandom_range(0, 16);
         return data_type'(v - 8);
      end
      if (sel < 11) begin
         case ($urandom_range(0, 5))
            0:       return INT_MIN;
            1:       return INT_MAX;
            2:       return INT_MIN + 1;
            3:       return INT_MAX - 1;
            4:       return -1;
            default: return 0;
         endcase
      end
      return data_type'($urandom);
   endfunction

   // Keys lean on stored values so that hits, near misses and duplicates occur.
   function automatic data_type pick_key();
      int unsigned sel;
      data_type    k;
      sel = $urandom_range(0, 19);
      k   = idx_store[$urandom_range(0, STORE_DEPTH - 1)];
      if (sel < 10) return k;
      if (sel < 13) return k + 1;
      if (sel < 15) return k - 1;
      if (sel < 17) return pick_value();
      return data_type'($urandom);
   endfunction

   // Only valid once every store entry has been written.
   task automatic random_item();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
         issue(FUNC_SEARCH, addr_type'($urandom), pick_key());
      end else if (sel < 88) begin
         issue(FUNC_WRITE, addr_type'($urandom), pick_value());
      end else if (sel < 94) begin
         issue(FUNC_CLEAR, addr_type'($urandom), data_type'($urandom));
      end else begin
         issue(FUNC_UNUSED, addr_type'($urandom), data_type'($urandom));
      end
   endtask

   // Nothing is written yet, so only keys above every maximum may be searched.
   task automatic test_empty_store();
      issue(FUNC_SEARCH, 4'hf, INT_MAX);
      issue(FUNC_UNUSED, 4'h5, -1);
   endtask

   task automatic test_fill_and_search();
      data_type fill [STORE_DEPTH];
      fill = '{INT_MIN, -1000, -5, -1,
               0, 7, 3, 100,
               1000, 256, 999, 4096,
               5000, 4097, 4500, 4999};
      for (int i = 0; i < STORE_DEPTH; i++) issue(FUNC_WRITE, addr_type'(i), fill[i]);
      issue(FUNC_SEARCH, '0, INT_MIN);
      issue(FUNC_SEARCH, '0, 3);
      issue(FUNC_SEARCH, '0, 4099);
   endtask

   // The block maximum keeps the overwritten value, so a search for 1 lands
   // in the second block and misses the copy in the last one.
   task automatic test_overwrite();
      issue(FUNC_WRITE, 4'hf, INT_MAX);
      issue(FUNC_WRITE, 4'hf, 1);
      issue(FUNC_SEARCH, '0, INT_MAX);
      issue(FUNC_SEARCH, '0, 1);
   endtask

   task automatic test_clear();
      issue(FUNC_CLEAR, '0, 0);
      issue(FUNC_SEARCH, '0, INT_MIN);
      issue(FUNC_WRITE, 4'h9, -7);
      issue(FUNC_SEARCH, '0, -7);
   endtask

   task automatic test_random_mix(input int unsigned count);
      repeat (count) random_item();
   endtask

   // The receiver stalls for a long stretch while items keep coming, so the
   // block fills up and holds off its input.
   task automatic test_output_backpressure();
      fork
         begin
            rsp_hold = 1'b1;
            repeat (300) @(posedge clock);
            rsp_hold = 1'b0;
         end
         repeat (12) random_item();
      join
   endtask

   // Receiver: random stall bursts, none once calm is set.
   initial begin
      int unsigned stall_left;
      stall_left   = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold) begin
            rsp_if.ready <= 1'b0;
         end else if (stall_left != 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 12);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      search_answer_type exp_ans;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (answer_q.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected response: found=%0d position=%0d",
                        rsp_if.found, rsp_if.position);
         end else begin
            exp_ans = answer_q.pop_front();
            if (rsp_if.found !== exp_ans.found || rsp_if.position !== exp_ans.position) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch: expected found=%0d position=%0d, got found=%0d position=%0d",
                           exp_ans.found, exp_ans.position, rsp_if.found, rsp_if.position);
            end
         end
      end
   end

   initial begin
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.func    <= FUNC_CLEAR;
      req_if.address <= '0;
      req_if.value   <= '0;
      foreach (blk_max[i]) blk_max[i] = INT_MIN;
      foreach (idx_store[i]) idx_store[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_store();
      test_fill_and_search();
      test_overwrite();
      test_clear();
      test_random_mix(1200);
      test_output_backpressure();
      calm = 1'b1;
      test_random_mix(300);
      req_if.valid <= 1'b0;

      while (answer_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Covered %0d searches (%0d hits, %0d misses), %0d writes, %0d clears",
               hit_count + miss_count, hit_count, miss_count, write_count, clear_count);
      $display("and %0d unused-code items, with random stalls and one long output hold.",
               other_count);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/bis_pkg.sv
rtl/core/bis_if.sv
rtl/core/bis_max_store.sv
rtl/core/bis_elem_store.sv
rtl/core/block_index_search_unit.sv
bench/tb.sv
